@@ sv/i2cm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg: shared definitions for the I2C master bit engine
// Command codes, reset values and the per-command phase counts.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Default width of the per-phase tick counter
	localparam int unsigned I2CM_COUNTER_BITS = 16;

	// Width of the phase length register and its reset value
	localparam int unsigned I2CM_TICKS_W       = 16;
	localparam logic [15:0] I2CM_TICKS_RESET   = 16'd10;

	localparam int unsigned I2CM_PHASE_W = 5;

	typedef enum logic [2:0] {
		MODE_START    = 3'd0,
		MODE_STOP     = 3'd1,
		MODE_SEND     = 3'd2,
		MODE_RECV     = 3'd3,
		MODE_SEND_ACK = 3'd4,
		MODE_RECV_ACK = 3'd5
	} mode_t;

	// Number of phases in each command's sequence
	function automatic logic [I2CM_PHASE_W-1:0] seq_length(input mode_t m);
		logic [I2CM_PHASE_W-1:0] len;
		case (m)
			MODE_START:    len = 5'd4;
			MODE_STOP:     len = 5'd3;
			MODE_SEND:     len = 5'd24;
			MODE_RECV:     len = 5'd25;
			MODE_SEND_ACK: len = 5'd3;
			default:       len = 5'd4;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

@@ sv/i2c_master_bit_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: I2C master line sequencer
// Turns start, stop, byte and acknowledge commands into timed SCL/SDA phases.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus timebase. It may carry a command
// (cmd_valid with mode, tx_byte, ack_level) and always carries the sampled
// SDA level. A command is taken only while no sequence runs; commands that
// arrive while busy, or with mode 6 or 7, are dropped. A taken command runs
// its first phase on the same tick. Every phase (one SCL write, one SDA write
// or one SDA sample) lasts phase_ticks ticks (0 acts as 1, and the length is
// clipped to the tick counter's range). Bytes go MSB first; a level of 1
// means the line is released. Each input word yields exactly one result word
// with the line drives, busy/done flags and the last received byte and ack.
// Throughput is one word per clock while the result is not stalled: the word
// is registered in the input register, then the sequencer state and result
// register update from it together.
// A stalled result holds in the output register; the input register keeps
// taking words until it holds one that cannot move on.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
	import i2cm_pkg::*;
#(
	parameter int unsigned COUNTER_BITS = I2CM_COUNTER_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	// configuration
	input  wire logic                    cfg_we,
	input  wire logic [I2CM_TICKS_W-1:0] cfg_data,

	// input words
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    cmd_valid,
	input  wire logic [2:0]              mode,
	input  wire logic [7:0]              tx_byte,
	input  wire logic                    ack_level,
	input  wire logic                    sda_in,

	// result words
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         scl_out,
	output logic                         sda_out,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [7:0]                   rx_data,
	output logic                         rx_ack
);

	// Width that holds both the phase length register and the counter range
	localparam int unsigned LIM_W = (COUNTER_BITS > I2CM_TICKS_W) ? COUNTER_BITS : I2CM_TICKS_W;
	localparam int unsigned CMP_W = LIM_W + 1;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [I2CM_TICKS_W-1:0] phase_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= I2CM_TICKS_RESET;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the pipeline advances when the result register is free
	// or being drained this cycle.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic res_valid_q;
	logic advance;
	logic in_take;
	logic process;

	assign advance  = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign process  = valid_s1 && advance;

	// Input register
	logic       cmd_valid_s1;
	logic [2:0] mode_s1;
	logic [7:0] tx_byte_s1;
	logic       ack_level_s1;
	logic       sda_in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_valid_s1 <= cmd_valid;
			mode_s1      <= mode;
			tx_byte_s1   <= tx_byte;
			ack_level_s1 <= ack_level;
			sda_in_s1    <= sda_in;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	logic                    running_q;
	mode_t                   act_mode_q;
	logic [I2CM_PHASE_W-1:0] phase_q;
	logic [COUNTER_BITS-1:0] tick_q;
	logic [1:0]              sub_q;     // step within a bit: drive/raise/lower to send, raise/sample/lower to receive
	logic [2:0]              bit_q;     // bit position, 0 is the MSB
	logic [7:0]              shift_q;
	logic [7:0]              rx_byte_q;
	logic                    scl_q;
	logic                    sda_q;
	logic                    ack_q;

	// Next-state values
	logic                    running_n;
	mode_t                   act_mode_n;
	logic [I2CM_PHASE_W-1:0] phase_n;
	logic [COUNTER_BITS-1:0] tick_n;
	logic [1:0]              sub_n;
	logic [2:0]              bit_n;
	logic [7:0]              shift_n;
	logic [7:0]              rx_byte_n;
	logic                    scl_n;
	logic                    sda_n;
	logic                    ack_n;
	logic                    done_n;

	// Effective phase length: zero acts as one, clip to counter range
	logic [LIM_W-1:0] ticks_ext;
	logic [LIM_W-1:0] cap;
	logic [LIM_W-1:0] limit;
	logic [CMP_W-1:0] tick_inc;
	logic             phase_end;
	logic             start;
	logic             do_act;
	logic             step_bit;

	assign ticks_ext = LIM_W'(phase_ticks_q);
	assign cap       = LIM_W'({COUNTER_BITS{1'b1}});

	always_comb begin
		if (ticks_ext == '0) begin
			limit = LIM_W'(1);
		end else if (ticks_ext > cap) begin
			limit = cap;
		end else begin
			limit = ticks_ext;
		end
	end

	always_comb begin
		start = !running_q && cmd_valid_s1 && (mode_s1 <= 3'(MODE_RECV_ACK));

		running_n  = running_q;
		act_mode_n = act_mode_q;
		phase_n    = phase_q;
		tick_n     = tick_q;
		sub_n      = sub_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		rx_byte_n  = rx_byte_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		ack_n      = ack_q;
		done_n     = 1'b0;
		tick_inc   = '0;
		phase_end  = 1'b0;
		do_act     = 1'b0;
		step_bit   = 1'b0;

		// Take a new command: restart the phase list and, for send, receive and send-ack, load the shifter
		if (start) begin
			running_n  = 1'b1;
			act_mode_n = mode_t'(mode_s1);
			phase_n    = '0;
			tick_n     = '0;
			sub_n      = 2'd0;
			bit_n      = 3'd0;
			case (mode_t'(mode_s1))
				MODE_SEND:     shift_n = tx_byte_s1;
				MODE_RECV:     shift_n = 8'h00;
				MODE_SEND_ACK: shift_n = {7'd0, ack_level_s1};
				default:       shift_n = shift_q;
			endcase
		end

		if (running_n) begin
			do_act = (tick_n == '0);

			// Perform the phase action on the first tick of the phase
			if (do_act) begin
				case (act_mode_n)
					MODE_START: begin
						case (phase_n)
							5'd0:    sda_n = 1'b1;
							5'd1:    scl_n = 1'b1;
							5'd2:    sda_n = 1'b0;
							default: scl_n = 1'b0;
						endcase
					end
					MODE_STOP: begin
						case (phase_n)
							5'd0:    sda_n = 1'b0;
							5'd1:    scl_n = 1'b1;
							default: sda_n = 1'b1;
						endcase
					end
					MODE_SEND: begin
						case (sub_n)
							2'd0:    sda_n = shift_n[~bit_n];
							2'd1:    scl_n = 1'b1;
							default: scl_n = 1'b0;
						endcase
					end
					MODE_RECV: begin
						if (phase_n == '0) begin
							sda_n = 1'b1;
						end else begin
							case (sub_n)
								2'd0: scl_n = 1'b1;
								2'd1: begin
									if (sda_in_s1) begin
										shift_n[~bit_n] = 1'b1;
									end
								end
								default: scl_n = 1'b0;
							endcase
						end
					end
					MODE_SEND_ACK: begin
						case (phase_n)
							5'd0:    sda_n = shift_n[0];
							5'd1:    scl_n = 1'b1;
							default: scl_n = 1'b0;
						endcase
					end
					default: begin
						case (phase_n)
							5'd0:    sda_n = 1'b1;
							5'd1:    scl_n = 1'b1;
							5'd2:    ack_n = sda_in_s1;
							default: scl_n = 1'b0;
						endcase
					end
				endcase
			end

			// Count ticks; a wrap of the counter also ends the phase
			tick_inc  = CMP_W'(tick_n) + CMP_W'(1);
			phase_end = (tick_inc >= CMP_W'(limit));

			if (phase_end) begin
				tick_n = '0;
				// The receive preamble phase does not move the bit position
				step_bit = !((act_mode_n == MODE_RECV) && (phase_n == '0));
				if (step_bit) begin
					if (sub_n == 2'd2) begin
						sub_n = 2'd0;
						bit_n = bit_n + 3'd1;
					end else begin
						sub_n = sub_n + 2'd1;
					end
				end
				phase_n = phase_n + 5'd1;
				if (phase_n >= seq_length(act_mode_n)) begin
					running_n = 1'b0;
					phase_n   = '0;
					done_n    = 1'b1;
					if (act_mode_n == MODE_RECV) begin
						rx_byte_n = shift_n;
					end
				end
			end else begin
				tick_n = tick_inc[COUNTER_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			act_mode_q <= MODE_START;
			phase_q    <= '0;
			tick_q     <= '0;
			sub_q      <= 2'd0;
			bit_q      <= 3'd0;
			shift_q    <= 8'h00;
			rx_byte_q  <= 8'h00;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_q      <= 1'b0;
		end else if (process) begin
			running_q  <= running_n;
			act_mode_q <= act_mode_n;
			phase_q    <= phase_n;
			tick_q     <= tick_n;
			sub_q      <= sub_n;
			bit_q      <= bit_n;
			shift_q    <= shift_n;
			rx_byte_q  <= rx_byte_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			ack_q      <= ack_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register: hold while stalled
	// ------------------------------------------------------------------
	logic       scl_res_q;
	logic       sda_res_q;
	logic       busy_res_q;
	logic       done_res_q;
	logic [7:0] rx_data_q;
	logic       rx_ack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			scl_res_q  <= scl_n;
			sda_res_q  <= sda_n;
			busy_res_q <= running_n;
			done_res_q <= done_n;
			rx_data_q  <= rx_byte_n;
			rx_ack_q   <= ack_n;
		end
	end

	assign out_valid = res_valid_q;
	assign scl_out   = scl_res_q;
	assign sda_out   = sda_res_q;
	assign busy_res  = busy_res_q;
	assign done_res  = done_res_q;
	assign rx_data   = rx_data_q;
	assign rx_ack    = rx_ack_q;

endmodule
`default_nettype wire
